// File: rtl/pid_controller_clamped_top_defines.svh
// Assertion macros shared by the PID controller checker.
`ifndef PID_CONTROLLER_CLAMPED_TOP_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_TOP_DEFINES_SVH

// Check cons in the same cycle as ante; hold off during reset.
`define PIDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidc: same-cycle check failed");

// Check cons in the cycle after ante; hold off during reset.
`define PIDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidc: next-cycle check failed");

// Check cons at every edge while reset is asserted.
`define PIDC_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |-> (cons)) \
        else $error("pidc: reset check failed");

`endif

// File: rtl/pidc_pkg.sv
// Shared types and constants of the clamped PID controller.
package pidc_pkg;

    localparam int GAIN_WIDTH     = 16;
    localparam int COEFF_WIDTH    = 17;
    localparam int COEFF_FRAC     = 16;
    localparam logic [COEFF_WIDTH-1:0] COEFF_ONE = 17'h10000;

    // Serial multiplier operand: 16-bit signed gains and the 17-bit unsigned
    // coefficient all fit an 18-bit signed word.
    localparam int MUL_B_WIDTH    = 18;
    localparam int CNT_WIDTH      = $clog2(MUL_B_WIDTH);

    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        REG_KP           = 3'd0,
        REG_KI_PER_STEP  = 3'd1,
        REG_KD           = 3'd2,
        REG_INTEGRAL_MIN = 3'd3,
        REG_INTEGRAL_MAX = 3'd4,
        REG_OUTPUT_MIN   = 3'd5,
        REG_OUTPUT_MAX   = 3'd6,
        REG_FILTER_COEFF = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } smul_ctrl_t;

endpackage

// File: rtl/pidc_regs.sv
// APB configuration registers of the clamped PID controller.
module pidc_regs
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic        [APB_ADDR_WIDTH-1:0]   paddr,
    input  logic        [APB_DATA_WIDTH-1:0]   pwdata,
    output logic        [APB_DATA_WIDTH-1:0]   prdata,
    output logic signed [GAIN_WIDTH-1:0]       kp,
    output logic signed [GAIN_WIDTH-1:0]       ki_per_step,
    output logic signed [GAIN_WIDTH-1:0]       kd,
    output logic signed [DATA_WIDTH-1:0]       integral_min,
    output logic signed [DATA_WIDTH-1:0]       integral_max,
    output logic signed [DATA_WIDTH-1:0]       output_min,
    output logic signed [DATA_WIDTH-1:0]       output_max,
    output logic        [COEFF_WIDTH-1:0]      filter_coeff
);

    // One in Q2.(DATA_WIDTH-2)
    localparam logic signed [DATA_WIDTH-1:0] LIMIT_ONE = DATA_WIDTH'(1) << (DATA_WIDTH - 2);

    logic signed [GAIN_WIDTH-1:0]  kp_reg;
    logic signed [GAIN_WIDTH-1:0]  ki_reg;
    logic signed [GAIN_WIDTH-1:0]  kd_reg;
    logic signed [DATA_WIDTH-1:0]  imin_reg;
    logic signed [DATA_WIDTH-1:0]  imax_reg;
    logic signed [DATA_WIDTH-1:0]  omin_reg;
    logic signed [DATA_WIDTH-1:0]  omax_reg;
    logic        [COEFF_WIDTH-1:0] coeff_reg;
    logic                          wr_en;
    reg_idx_t                      idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            imin_reg  <= -LIMIT_ONE;
            imax_reg  <= LIMIT_ONE;
            omin_reg  <= -LIMIT_ONE;
            omax_reg  <= LIMIT_ONE;
            coeff_reg <= COEFF_ONE;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_KP:           kp_reg    <= pwdata[GAIN_WIDTH-1:0];
                REG_KI_PER_STEP:  ki_reg    <= pwdata[GAIN_WIDTH-1:0];
                REG_KD:           kd_reg    <= pwdata[GAIN_WIDTH-1:0];
                REG_INTEGRAL_MIN: imin_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_INTEGRAL_MAX: imax_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_OUTPUT_MIN:   omin_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_OUTPUT_MAX:   omax_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_FILTER_COEFF: coeff_reg <= pwdata[COEFF_WIDTH-1:0];
                default:          kp_reg    <= kp_reg;
            endcase
        end
    end

    // Read back signed registers sign-extended
    always_comb
    begin
        unique case (idx)
            REG_KP:           prdata = APB_DATA_WIDTH'(kp_reg);
            REG_KI_PER_STEP:  prdata = APB_DATA_WIDTH'(ki_reg);
            REG_KD:           prdata = APB_DATA_WIDTH'(kd_reg);
            REG_INTEGRAL_MIN: prdata = APB_DATA_WIDTH'(imin_reg);
            REG_INTEGRAL_MAX: prdata = APB_DATA_WIDTH'(imax_reg);
            REG_OUTPUT_MIN:   prdata = APB_DATA_WIDTH'(omin_reg);
            REG_OUTPUT_MAX:   prdata = APB_DATA_WIDTH'(omax_reg);
            REG_FILTER_COEFF: prdata = APB_DATA_WIDTH'(coeff_reg);
            default:          prdata = '0;
        endcase
    end

    assign kp           = kp_reg;
    assign ki_per_step  = ki_reg;
    assign kd           = kd_reg;
    assign integral_min = imin_reg;
    assign integral_max = imax_reg;
    assign output_min   = omin_reg;
    assign output_max   = omax_reg;
    assign filter_coeff = coeff_reg;

endmodule

// File: rtl/pidc_smul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per step.
module pidc_smul
    import pidc_pkg::*;
#(
    parameter int A_W = 17,
    parameter int B_W = 18
)
(
    input  logic                     clk,
    input  smul_ctrl_t               ctrl,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W:0]  prod
);

    localparam int AX = A_W + 1;

    logic signed [A_W-1:0] a_reg;
    logic        [B_W-1:0] b_reg;
    logic signed [AX-1:0]  p_hi_reg;
    logic        [B_W-1:0] p_lo_reg;
    logic signed [AX-1:0]  a_ext;
    logic signed [AX-1:0]  term;
    logic signed [AX-1:0]  sum;

    assign a_ext = AX'(a_reg);

    // The top multiplier bit carries negative weight: subtract on the last step
    always_comb
    begin
        if (!b_reg[0])
            term = '0;
        else if (ctrl.last)
            term = -a_ext;
        else
            term = a_ext;
        sum = p_hi_reg + term;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg    <= a;
            b_reg    <= b;
            p_hi_reg <= '0;
            p_lo_reg <= '0;
        end
        else if (ctrl.step)
        begin
            b_reg    <= b_reg >> 1;
            p_hi_reg <= {sum[AX-1], sum[AX-1:1]};
            p_lo_reg <= {sum[0], p_lo_reg[B_W-1:1]};
        end
    end

    assign prod = {p_hi_reg, p_lo_reg};

endmodule

// File: rtl/pid_controller_clamped_top.sv
// Top level of the clamped PID controller with filtered derivative.
//
// Channel   Handshake                    Payload
// -------   --------------------------   ------------------------------------------
// input     in_valid / in_ready          error, clear_integral
// output    out_valid / out_ready        drive, output_clamped, integral_clamped
// config    APB psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// A request runs through two serial multiplier passes (P, I and filter products in parallel,
// then the D product) and four control steps (accumulate, integral clamp, sum, final clamp)
// before a valid result; a new request is taken only once the block is back in idle.
// Reset (asynchronous, active low) clears the integral and filtered error and restores
// the register defaults.
// A waiting result blocks nothing until the next request reaches its final clamp step.
module pid_controller_clamped_top
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [DATA_WIDTH-1:0]     error,
    input  logic                             clear_integral,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [DATA_WIDTH-1:0]     drive,
    output logic                             output_clamped,
    output logic                             integral_clamped,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic        [APB_ADDR_WIDTH-1:0] paddr,
    input  logic        [APB_DATA_WIDTH-1:0] pwdata,
    output logic        [APB_DATA_WIDTH-1:0] prdata,
    output logic                             pready
);

    // Lane multiplicand: error, error difference or filter step (one bit of headroom)
    localparam int AW = DATA_WIDTH + 1;
    localparam int BW = MUL_B_WIDTH;
    // Full product width of a lane
    localparam int PW = AW + BW + 1;
    // Integral sum and output sum widths
    localparam int IW = PW + 1;
    localparam int SW = PW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_ACC,
        ST_ICLAMP,
        ST_MUL2,
        ST_SUM,
        ST_FIN
    } state_t;

    // Configuration
    logic signed [GAIN_WIDTH-1:0]  kp;
    logic signed [GAIN_WIDTH-1:0]  ki_per_step;
    logic signed [GAIN_WIDTH-1:0]  kd;
    logic signed [DATA_WIDTH-1:0]  integral_min;
    logic signed [DATA_WIDTH-1:0]  integral_max;
    logic signed [DATA_WIDTH-1:0]  output_min;
    logic signed [DATA_WIDTH-1:0]  output_max;
    logic        [COEFF_WIDTH-1:0] filter_coeff;

    // Control
    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic                   in_acc;
    logic                   mul_last;
    logic                   out_load;
    logic                   out_valid_reg;
    smul_ctrl_t             ctrl0;
    smul_ctrl_t             ctrl12;

    // Controller state and result registers
    logic signed [DATA_WIDTH-1:0] int_acc_reg;
    logic signed [DATA_WIDTH-1:0] filt_prev_reg;
    logic                         ihit_reg;
    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic                         output_clamped_reg;
    logic                         integral_clamped_reg;

    // Datapath
    logic                         clr_reg;
    logic signed [PW-1:0]         p_term_reg;
    logic signed [IW-1:0]         int_sum_reg;
    logic signed [SW-1:0]         sum_reg;

    logic        [COEFF_WIDTH-1:0] coeff_eff;
    logic signed [AW-1:0]          lane0_a;
    logic signed [BW-1:0]          lane0_b;
    logic signed [AW-1:0]          err_ext;
    logic signed [AW-1:0]          diff;
    logic signed [BW-1:0]          ki_ext;
    logic signed [BW-1:0]          coeff_ext;
    logic signed [PW-1:0]          prod0;
    logic signed [PW-1:0]          prod1;
    logic signed [PW-1:0]          prod2;

    logic signed [PW-1:0]          p_term;
    logic signed [PW-1:0]          i_term;
    logic signed [PW-1:0]          d_term;
    logic signed [AW-1:0]          yd;
    logic signed [AW-1:0]          y_new;
    logic signed [DATA_WIDTH-1:0]  int_base;

    logic signed [IW-1:0]          imin_ext;
    logic signed [IW-1:0]          imax_ext;
    logic                          i_over;
    logic                          i_under;
    logic signed [IW-1:0]          i_clamped;

    logic signed [SW-1:0]          omin_ext;
    logic signed [SW-1:0]          omax_ext;
    logic                          o_over;
    logic                          o_under;
    logic signed [SW-1:0]          o_clamped;

    pidc_regs #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .kp           (kp),
        .ki_per_step  (ki_per_step),
        .kd           (kd),
        .integral_min (integral_min),
        .integral_max (integral_max),
        .output_min   (output_min),
        .output_max   (output_max),
        .filter_coeff (filter_coeff)
    );

    assign pready = 1'b1;

    // ---------------------------------------------------------------------
    // Handshake and sequencing
    // ---------------------------------------------------------------------
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign mul_last = (cnt_reg == CNT_WIDTH'(BW - 1));
    // Load the result only once the previous one has been taken
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc)   state_next = ST_MUL1;
            ST_MUL1:   if (mul_last) state_next = ST_ACC;
            ST_ACC:    state_next = ST_ICLAMP;
            ST_ICLAMP: state_next = ST_MUL2;
            ST_MUL2:   if (mul_last) state_next = ST_SUM;
            ST_SUM:    state_next = ST_FIN;
            ST_FIN:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Multiplier lanes
    //   lane 0: kp * error in the first pass, kd * filter step in the second
    //   lane 1: ki_per_step * error
    //   lane 2: coefficient * (error - filtered_prev)
    // ---------------------------------------------------------------------
    // Treat a coefficient above one as unfiltered
    assign coeff_eff = (filter_coeff > COEFF_ONE) ? COEFF_ONE : filter_coeff;
    assign coeff_ext = BW'({1'b0, coeff_eff});
    assign err_ext   = AW'(error);
    assign diff      = err_ext - AW'(filt_prev_reg);
    assign ki_ext    = BW'(ki_per_step);

    assign lane0_a = (state_reg == ST_IDLE) ? err_ext : yd;
    assign lane0_b = (state_reg == ST_IDLE) ? BW'(kp) : BW'(kd);

    assign ctrl0.load  = in_acc || (state_reg == ST_ACC);
    assign ctrl0.step  = (state_reg == ST_MUL1) || (state_reg == ST_MUL2);
    assign ctrl0.last  = mul_last;
    assign ctrl12.load = in_acc;
    assign ctrl12.step = (state_reg == ST_MUL1);
    assign ctrl12.last = mul_last;

    pidc_smul #(
        .A_W (AW),
        .B_W (BW)
    ) u_lane0 (
        .clk  (clk),
        .ctrl (ctrl0),
        .a    (lane0_a),
        .b    (lane0_b),
        .prod (prod0)
    );

    pidc_smul #(
        .A_W (AW),
        .B_W (BW)
    ) u_lane1 (
        .clk  (clk),
        .ctrl (ctrl12),
        .a    (err_ext),
        .b    (ki_ext),
        .prod (prod1)
    );

    pidc_smul #(
        .A_W (AW),
        .B_W (BW)
    ) u_lane2 (
        .clk  (clk),
        .ctrl (ctrl12),
        .a    (diff),
        .b    (coeff_ext),
        .prod (prod2)
    );

    // ---------------------------------------------------------------------
    // Term arithmetic; all right shifts floor
    // ---------------------------------------------------------------------
    assign p_term   = prod0 >>> GAIN_FRAC_BITS;
    assign d_term   = prod0 >>> GAIN_FRAC_BITS;
    assign i_term   = prod1 >>> GAIN_FRAC_BITS;
    // Filter step y - prev; it never exceeds the error difference in size
    assign yd       = prod2[COEFF_FRAC +: AW];
    assign y_new    = AW'(filt_prev_reg) + yd;
    assign int_base = clr_reg ? '0 : int_acc_reg;

    // Clamp: max first, then min, so the min wins when the limits cross
    assign imin_ext  = IW'(integral_min);
    assign imax_ext  = IW'(integral_max);
    assign i_over    = int_sum_reg > imax_ext;
    assign i_under   = i_over ? (imax_ext < imin_ext) : (int_sum_reg < imin_ext);
    assign i_clamped = i_under ? imin_ext : (i_over ? imax_ext : int_sum_reg);

    assign omin_ext  = SW'(output_min);
    assign omax_ext  = SW'(output_max);
    assign o_over    = sum_reg > omax_ext;
    assign o_under   = o_over ? (omax_ext < omin_ext) : (sum_reg < omin_ext);
    assign o_clamped = o_under ? omin_ext : (o_over ? omax_ext : sum_reg);

    // ---------------------------------------------------------------------
    // State, controller state and registered outputs
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            cnt_reg              <= '0;
            out_valid_reg        <= 1'b0;
            drive_reg            <= '0;
            output_clamped_reg   <= 1'b0;
            integral_clamped_reg <= 1'b0;
            int_acc_reg          <= '0;
            filt_prev_reg        <= '0;
            ihit_reg             <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Advance the bit counter through each multiplier pass
            if (((state_reg == ST_MUL1) || (state_reg == ST_MUL2)) && !mul_last)
                cnt_reg <= cnt_reg + CNT_WIDTH'(1);
            else
                cnt_reg <= '0;

            if (state_reg == ST_ACC)
                filt_prev_reg <= y_new[DATA_WIDTH-1:0];

            if (state_reg == ST_ICLAMP)
            begin
                int_acc_reg <= i_clamped[DATA_WIDTH-1:0];
                ihit_reg    <= i_over || i_under;
            end

            if (out_load)
            begin
                out_valid_reg        <= 1'b1;
                drive_reg            <= o_clamped[DATA_WIDTH-1:0];
                output_clamped_reg   <= o_over || o_under;
                integral_clamped_reg <= ihit_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath holding registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            clr_reg <= clear_integral;
        if (state_reg == ST_ACC)
        begin
            p_term_reg  <= p_term;
            int_sum_reg <= IW'(i_term) + IW'(int_base);
        end
        if (state_reg == ST_SUM)
            sum_reg <= SW'(p_term_reg) + SW'(int_acc_reg) + SW'(d_term);
    end

    assign out_valid        = out_valid_reg;
    assign drive            = drive_reg;
    assign output_clamped   = output_clamped_reg;
    assign integral_clamped = integral_clamped_reg;

endmodule

// File: rtl/pidc_checker.sv
// Port-level checker of the clamped PID controller, bound to the top level.
`include "pid_controller_clamped_top_defines.svh"

module pidc_checker
#(
    parameter int DATA_WIDTH = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] drive,
    input logic                         output_clamped,
    input logic                         integral_clamped
);

    // Result fields as one word for the hold check
    logic [DATA_WIDTH+1:0] res;

    assign res = {drive, output_clamped, integral_clamped};

    // A stalled result holds
    `PIDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res))

    // An accepted request keeps the input side busy
    `PIDC_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)

    // A new result appears together with a free input side
    `PIDC_ASSERT_IMPL(a_result_frees_input, clk, rst_n, $rose(out_valid), in_ready)

    // No result during reset
    `PIDC_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_valid)

endmodule

bind pid_controller_clamped_top pidc_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pidc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .drive            (drive),
    .output_clamped   (output_clamped),
    .integral_clamped (integral_clamped)
);

// File: test/pidc_drive_checker.sv
// Drive predictor and result checker for the clamped PID controller.
`timescale 1ns / 100ps

module pidc_drive_checker
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] error,
    input  logic                         clear_integral,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [DATA_WIDTH-1:0] drive,
    input  logic                         output_clamped,
    input  logic                         integral_clamped,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [APB_DATA_WIDTH-1:0]    pwdata,
    output int                           fail_count,
    output int                           pending
);

    // 1.0 in Q2.14
    localparam logic signed [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(1) << (DATA_WIDTH - 2);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         output_clamped;
        logic                         integral_clamped;
    } drive_result_t;

    drive_result_t expected_drive_q[$];

    logic signed [GAIN_WIDTH-1:0]  kp_gain;
    logic signed [GAIN_WIDTH-1:0]  ki_gain;
    logic signed [GAIN_WIDTH-1:0]  kd_gain;
    logic signed [DATA_WIDTH-1:0]  integ_lo;
    logic signed [DATA_WIDTH-1:0]  integ_hi;
    logic signed [DATA_WIDTH-1:0]  drive_lo;
    logic signed [DATA_WIDTH-1:0]  drive_hi;
    logic        [COEFF_WIDTH-1:0] filt_coeff;

    logic signed [DATA_WIDTH-1:0]  integ_acc;
    logic signed [DATA_WIDTH-1:0]  filt_prev;

    // Max first, then min: with the limits crossed the min wins.
    function automatic longint clamp_wide(input longint v, input longint lo, input longint hi,
                                          output logic hit);
        hit = 1'b0;
        if (v > hi)
        begin
            v   = hi;
            hit = 1'b1;
        end
        if (v < lo)
        begin
            v   = lo;
            hit = 1'b1;
        end
        return v;
    endfunction

    // Advance the controller state by one error sample and return the drive.
    function automatic drive_result_t predict_drive(input logic signed [DATA_WIDTH-1:0] err,
                                                    input logic clr);
        longint        e;
        longint        coeff;
        longint        acc;
        longint        prop;
        longint        filt;
        longint        deriv;
        longint        sum;
        logic          ihit;
        logic          ohit;
        drive_result_t r;

        e     = err;
        coeff = (filt_coeff > COEFF_ONE) ? longint'(COEFF_ONE) : longint'(filt_coeff);
        acc   = clr ? 64'sd0 : longint'(integ_acc);

        prop  = (longint'(kp_gain) * e) >>> GAIN_FRAC_BITS;
        acc   = clamp_wide(acc + ((longint'(ki_gain) * e) >>> GAIN_FRAC_BITS),
                           integ_lo, integ_hi, ihit);
        filt  = longint'(filt_prev) + ((coeff * (e - longint'(filt_prev))) >>> COEFF_FRAC);
        deriv = (longint'(kd_gain) * (filt - longint'(filt_prev))) >>> GAIN_FRAC_BITS;
        sum   = clamp_wide(prop + acc + deriv, drive_lo, drive_hi, ohit);

        integ_acc = acc[DATA_WIDTH-1:0];
        filt_prev = filt[DATA_WIDTH-1:0];

        r.drive            = sum[DATA_WIDTH-1:0];
        r.output_clamped   = ohit;
        r.integral_clamped = ihit;
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        drive_result_t got;
        drive_result_t want;

        if (!rst_n)
        begin
            kp_gain    = '0;
            ki_gain    = '0;
            kd_gain    = '0;
            integ_lo   = -ONE_Q;
            integ_hi   = ONE_Q;
            drive_lo   = -ONE_Q;
            drive_hi   = ONE_Q;
            filt_coeff = COEFF_ONE;
            integ_acc  = '0;
            filt_prev  = '0;
            fail_count = 0;
            expected_drive_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{drive, output_clamped, integral_clamped};
                if (expected_drive_q.size() == 0)
                begin
                    $display("%0t: drive %0d arrived with no request pending", $time, drive);
                    fail_count++;
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (got.drive !== want.drive)
                    begin
                        $display("%0t: drive expected %0d, got %0d",
                                 $time, want.drive, got.drive);
                        fail_count++;
                    end
                    if (got.output_clamped !== want.output_clamped)
                    begin
                        $display("%0t: output_clamped expected %0b, got %0b",
                                 $time, want.output_clamped, got.output_clamped);
                        fail_count++;
                    end
                    if (got.integral_clamped !== want.integral_clamped)
                    begin
                        $display("%0t: integral_clamped expected %0b, got %0b",
                                 $time, want.integral_clamped, got.integral_clamped);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                expected_drive_q.push_back(predict_drive(error, clear_integral));

            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]))
                    REG_KP:           kp_gain    = pwdata[GAIN_WIDTH-1:0];
                    REG_KI_PER_STEP:  ki_gain    = pwdata[GAIN_WIDTH-1:0];
                    REG_KD:           kd_gain    = pwdata[GAIN_WIDTH-1:0];
                    REG_INTEGRAL_MIN: integ_lo   = pwdata[DATA_WIDTH-1:0];
                    REG_INTEGRAL_MAX: integ_hi   = pwdata[DATA_WIDTH-1:0];
                    REG_OUTPUT_MIN:   drive_lo   = pwdata[DATA_WIDTH-1:0];
                    REG_OUTPUT_MAX:   drive_hi   = pwdata[DATA_WIDTH-1:0];
                    REG_FILTER_COEFF: filt_coeff = pwdata[COEFF_WIDTH-1:0];
                    default:          ;
                endcase
            end
        end
        pending <= expected_drive_q.size();
    end

endmodule

// File: test/tb_pid_controller_clamped_top.sv
// Stimulus, clocking and verdict for the clamped PID controller testbench.
`timescale 1ns / 100ps

module tb_pid_controller_clamped_top;
    import pidc_pkg::*;

    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_GAP        = 14;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int PHASE_ITEMS    = 50;

    // Idle modes: none, uniform gaps, occasional gaps
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_EVERY  = 1;
    localparam int IDLE_SPARSE = 2;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [DATA_WIDTH-1:0] error;
    logic                         clear_integral;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         output_clamped;
    logic                         integral_clamped;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_WIDTH-1:0]    paddr;
    logic [APB_DATA_WIDTH-1:0]    pwdata;
    logic [APB_DATA_WIDTH-1:0]    prdata;
    logic                         pready;

    int fail_count;
    int pending;
    int idle_cycles;
    int in_mode;
    int out_mode;
    int ready_gap;
    int walk_level;
    int walk_step;

    always #(CLK_PERIOD / 2) clk = ~clk;

    pid_controller_clamped_top #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .error            (error),
        .clear_integral   (clear_integral),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drive            (drive),
        .output_clamped   (output_clamped),
        .integral_clamped (integral_clamped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Predict every accepted request and compare each accepted drive against it.
    pidc_drive_checker #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_drive_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .error            (error),
        .clear_integral   (clear_integral),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drive            (drive),
        .output_clamped   (output_clamped),
        .integral_clamped (integral_clamped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // Draw the wait before the next request or the next result.
    function automatic int draw_gap(input int mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_EVERY: return $urandom_range(0, MAX_GAP);
            default:    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
        endcase
    endfunction

    // Mostly a random walk so the integral and the filter see smooth signals;
    // mix in full-range noise and the field extremes.
    function automatic logic signed [DATA_WIDTH-1:0] next_error();
        case ($urandom_range(0, 9))
            0: return DATA_WIDTH'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    3:       return 16'shffff;
                    default: return 16'sh0001;
                endcase
            end
            default:
            begin
                walk_level = walk_level + int'($urandom_range(0, 2 * walk_step)) - walk_step;
                if (walk_level > 32767)
                    walk_level = 32767;
                if (walk_level < -32768)
                    walk_level = -32768;
                return DATA_WIDTH'(walk_level);
            end
        endcase
    endfunction

    function automatic logic signed [GAIN_WIDTH-1:0] rand_gain();
        int v;
        v = int'($urandom_range(0, 1024)) - 512;
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3, 4:    return GAIN_WIDTH'($urandom);
            default: return GAIN_WIDTH'(v);
        endcase
    endfunction

    // Ordered limits most of the time; sometimes full range, equal or crossed.
    function automatic void pick_limits(output logic signed [DATA_WIDTH-1:0] lo,
                                        output logic signed [DATA_WIDTH-1:0] hi);
        int a;
        int b;
        a = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 7))
            0:
            begin
                lo = 16'sh8000;
                hi = 16'sh7fff;
            end
            1:
            begin
                lo = DATA_WIDTH'(a);
                hi = DATA_WIDTH'(a);
            end
            2:
            begin
                lo = DATA_WIDTH'((a > b) ? a : b);
                hi = DATA_WIDTH'((a > b) ? b : a);
            end
            3:
            begin
                lo = -16'sd16384;
                hi = 16'sd16384;
            end
            default:
            begin
                lo = DATA_WIDTH'((a < b) ? a : b);
                hi = DATA_WIDTH'((a < b) ? b : a);
            end
        endcase
    endfunction

    // Include codes above one, which the block treats as unfiltered.
    function automatic logic [COEFF_WIDTH-1:0] rand_coeff();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COEFF_ONE;
            2:       return COEFF_WIDTH'($urandom_range(65537, 131071));
            3:       return 17'd1;
            4:       return 17'd65535;
            5:       return COEFF_WIDTH'($urandom_range(0, 4096));
            default: return COEFF_WIDTH'($urandom_range(0, 65536));
        endcase
    endfunction

    // Setup cycle, then access cycle; leave the bus selected so back-to-back
    // writes do not touch psel twice in one step.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
    endtask

    // Write every register, then release the bus. Call only with the block idle.
    task automatic load_config(input logic signed [GAIN_WIDTH-1:0] kp_v,
                               input logic signed [GAIN_WIDTH-1:0] ki_v,
                               input logic signed [GAIN_WIDTH-1:0] kd_v,
                               input logic signed [DATA_WIDTH-1:0] imin_v,
                               input logic signed [DATA_WIDTH-1:0] imax_v,
                               input logic signed [DATA_WIDTH-1:0] omin_v,
                               input logic signed [DATA_WIDTH-1:0] omax_v,
                               input logic [COEFF_WIDTH-1:0]       coeff_v);
        write_reg(REG_KP,           APB_DATA_WIDTH'(kp_v));
        write_reg(REG_KI_PER_STEP,  APB_DATA_WIDTH'(ki_v));
        write_reg(REG_KD,           APB_DATA_WIDTH'(kd_v));
        write_reg(REG_INTEGRAL_MIN, APB_DATA_WIDTH'(imin_v));
        write_reg(REG_INTEGRAL_MAX, APB_DATA_WIDTH'(imax_v));
        write_reg(REG_OUTPUT_MIN,   APB_DATA_WIDTH'(omin_v));
        write_reg(REG_OUTPUT_MAX,   APB_DATA_WIDTH'(omax_v));
        write_reg(REG_FILTER_COEFF, APB_DATA_WIDTH'(coeff_v));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic randomize_config();
        logic signed [DATA_WIDTH-1:0] ilo;
        logic signed [DATA_WIDTH-1:0] ihi;
        logic signed [DATA_WIDTH-1:0] olo;
        logic signed [DATA_WIDTH-1:0] ohi;
        pick_limits(ilo, ihi);
        pick_limits(olo, ohi);
        load_config(rand_gain(), rand_gain(), rand_gain(), ilo, ihi, olo, ohi, rand_coeff());
    endtask

    // Present one request and hold it until accepted. Entered and left at a
    // falling edge; valid stays high so a zero gap runs back to back.
    task automatic send_sample(input logic signed [DATA_WIDTH-1:0] err, input logic clr);
        int gap;
        gap = draw_gap(in_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        error          <= err;
        clear_integral <= clr;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected drive has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Result side: either keep ready high ahead of the result, or hold it low
    // until a result shows up and stall it for the drawn number of cycles.
    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            ready_gap = draw_gap(out_mode);
            if (ready_gap > 0)
            begin
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (ready_gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b1;
        in_valid       = 1'b0;
        error          = '0;
        clear_integral = 1'b0;
        out_ready      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_mode        = IDLE_EVERY;
        out_mode       = IDLE_EVERY;
        walk_level     = 0;
        walk_step      = 256;

        // Drop reset just after time zero so every flop sees the falling edge,
        // hold it, then release it on a falling edge.
        #1 rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Register defaults straight out of reset.
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b1);

        // Extreme gains with full-range limits: the products of the extreme errors
        // overflow the 16-bit result and have to be carried wide into the clamps.
        settle();
        load_config(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                    16'sh8000, 16'sh7fff, COEFF_ONE);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shffff, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sh7fff, 1'b1);

        // Integral window that excludes zero, so a cleared integral lands
        // outside its limits; odd negative products check floor rounding;
        // coefficient above one must act as unfiltered.
        settle();
        load_config(-16'sd300, 16'sd777, -16'sd5000, 16'sd1000, 16'sd2000,
                    -16'sd100, 16'sd300, 17'd70000);
        send_sample(-16'sd3, 1'b1);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd12345, 1'b1);

        // Crossed limits: min above max, the min must win. Coefficient zero
        // freezes the filter so the derivative stays at zero.
        settle();
        load_config(16'sd256, 16'sd256, 16'sd256, 16'sd500, -16'sd500,
                    16'sd200, -16'sd200, 17'd0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // Smallest nonzero coefficient with the most negative proportional and derivative gains.
        settle();
        load_config(16'sh8000, 16'sd1, 16'sh8000, 16'sh8000, 16'sh7fff,
                    -16'sd16384, 16'sd16384, 17'd1);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b1);

        // Random phases: new settings, idle pattern and signal slope each time.
        for (int ph = 0; ph < RANDOM_ITEMS / PHASE_ITEMS; ph++)
        begin
            settle();
            randomize_config();
            in_mode  = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            out_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            case ($urandom_range(0, 2))
                0:       walk_step = 16;
                1:       walk_step = 256;
                default: walk_step = 2048;
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(next_error(), $urandom_range(0, 19) == 0);
        end

        // Drain, then give a late or stray result time to show up.
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
